>>> rtl/rsb_pkg.sv
package rsb_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_POS_X       = 3'd0,
    CFG_POS_Y       = 3'd1,
    CFG_SURF_WIDTH  = 3'd2,
    CFG_SURF_HEIGHT = 3'd3,
    CFG_BLIT_MODE   = 3'd4,
    CFG_MONO_COLOR  = 3'd5,
    CFG_COLOR_SHIFT = 3'd6
  } cfg_index_t;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_SHADOW = 2'd1;
  localparam logic [1:0] MODE_MIRROR = 2'd2;

  localparam logic [12:0] SURF_MAX       = 13'd4096;
  localparam logic [12:0] SURF_W_RESET   = 13'd320;
  localparam logic [12:0] SURF_H_RESET   = 13'd200;
  localparam logic [2:0]  HDR_LEN        = 3'd4;
  localparam logic [31:0] PREFIX_WORD    = 32'h0000_0002;
  localparam logic [7:0]  SKIP_FLAG      = 8'h80;
  localparam logic [7:0]  NIBBLE_LO      = 8'h0F;
  localparam logic [7:0]  NIBBLE_HI      = 8'hF0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } byte_t;

  typedef struct packed {
    logic        write_enable;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  color;
    logic        darken;
    logic        done_res;
  } pix_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [12:0]        surf_width;
    logic [12:0]        surf_height;
    logic [1:0]         blit_mode;
    logic [7:0]         mono_color;
    logic signed [4:0]  color_shift;
  } cfg_t;

endpackage

>>> rtl/rsb_cfg.sv
module rsb_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rsb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rsb_pkg::CFG_DATA_W-1:0]    cfg_data,
  output rsb_pkg::cfg_t                     cfg
);
  import rsb_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pos_x       <= '0;
      cfg.pos_y       <= '0;
      cfg.surf_width  <= SURF_W_RESET;
      cfg.surf_height <= SURF_H_RESET;
      cfg.blit_mode   <= MODE_NORMAL;
      cfg.mono_color  <= '0;
      cfg.color_shift <= '0;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_POS_X:       cfg.pos_x       <= cfg_data;
        CFG_POS_Y:       cfg.pos_y       <= cfg_data;
        CFG_SURF_WIDTH:  cfg.surf_width  <= cfg_data[12:0];
        CFG_SURF_HEIGHT: cfg.surf_height <= cfg_data[12:0];
        CFG_BLIT_MODE:   cfg.blit_mode   <= cfg_data[1:0];
        CFG_MONO_COLOR:  cfg.mono_color  <= cfg_data[7:0];
        CFG_COLOR_SHIFT: cfg.color_shift <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/rsb_pixel.sv
module rsb_pixel (
  input  rsb_pkg::cfg_t  cfg,
  input  logic [7:0]     data_byte,
  input  logic [15:0]    bitmap_width,
  input  logic [15:0]    src_col,
  input  logic [16:0]    src_row,
  output rsb_pkg::pix_t  pix
);
  import rsb_pkg::*;

  logic               mirror;
  logic               shadow;
  logic [12:0]        sw;
  logic [12:0]        sh;
  logic signed [18:0] x_off;
  logic signed [18:0] x;
  logic signed [18:0] y;
  logic               inside_surf;
  logic [7:0]         hue;
  logic signed [5:0]  nib_sum;
  logic [3:0]         nib_sat;

  assign mirror = cfg.blit_mode[1];
  assign shadow = !mirror && (cfg.blit_mode == MODE_SHADOW);
  assign sw = (cfg.surf_width  > SURF_MAX) ? SURF_MAX : cfg.surf_width;
  assign sh = (cfg.surf_height > SURF_MAX) ? SURF_MAX : cfg.surf_height;

  // mirrored column counts back from the rightmost sprite column
  assign x_off = mirror
    ? $signed({3'b000, bitmap_width}) - 19'sd1 - $signed({3'b000, src_col})
    : $signed({3'b000, src_col});
  assign x = $signed({{3{cfg.pos_x[15]}}, cfg.pos_x}) + x_off;
  assign y = $signed({{3{cfg.pos_y[15]}}, cfg.pos_y}) + $signed({2'b00, src_row});

  assign inside_surf = !x[18] && (x[17:0] < {5'd0, sw}) &&
                       !y[18] && (y[17:0] < {5'd0, sh});

  assign hue     = cfg.mono_color & NIBBLE_HI;
  assign nib_sum = $signed({2'b00, data_byte[3:0]}) +
                   $signed({cfg.color_shift[4], cfg.color_shift});
  assign nib_sat = nib_sum[5] ? 4'd0 : ((nib_sum > 6'sd15) ? 4'd15 : nib_sum[3:0]);

  always_comb begin
    pix = '0;
    if (inside_surf) begin
      pix.write_enable = 1'b1;
      pix.pixel_x      = x[11:0];
      pix.pixel_y      = y[11:0];
      if (shadow) begin
        pix.darken = 1'b1;
      end else if (hue != 8'd0) begin
        pix.color = {4'd0, nib_sat} | hue;
      end else if (cfg.color_shift != 5'sd0) begin
        pix.color = {4'd0, nib_sat} | (data_byte & NIBBLE_HI);
      end else begin
        pix.color = data_byte;
      end
    end
  end

endmodule

>>> rtl/rsb_decode.sv
module rsb_decode (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  rsb_pkg::byte_t item,
  input  rsb_pkg::cfg_t  cfg,
  output rsb_pkg::pix_t  result
);
  import rsb_pkg::*;

  logic [2:0]  header_count, header_count_next;
  logic        prefix_seen, prefix_seen_next;
  logic [23:0] header_bytes, header_bytes_next;
  logic [15:0] bitmap_width, bitmap_width_next;
  logic [15:0] bitmap_height, bitmap_height_next;
  logic [15:0] src_col, src_col_next;
  logic [16:0] src_row, src_row_next;
  logic [7:0]  run_left, run_left_next;
  logic        finished, finished_next;

  // state as seen by this byte, after a restart is applied
  logic [2:0]  hc_in;
  logic        ps_in;
  logic [23:0] hb_in;
  logic [15:0] col_in;
  logic [16:0] row_in;
  logic [7:0]  run_in;
  logic        fin_in;

  logic [7:0]  t;
  logic        lit;
  logic        do_adv;
  logic [7:0]  step_n;
  logic [16:0] col_sum;
  logic [15:0] hdr_height;
  pix_t        pix;

  assign t      = item.data_byte;
  assign hc_in  = item.first_byte ? 3'd0  : header_count;
  assign ps_in  = item.first_byte ? 1'b0  : prefix_seen;
  assign hb_in  = item.first_byte ? 24'd0 : header_bytes;
  assign col_in = item.first_byte ? 16'd0 : src_col;
  assign row_in = item.first_byte ? 17'd0 : src_row;
  assign run_in = item.first_byte ? 8'd0  : run_left;
  assign fin_in = item.first_byte ? 1'b0  : finished;

  assign col_sum    = {1'b0, col_in} + {9'd0, step_n};
  assign hdr_height = {t, hb_in[23:16]};

  rsb_pixel u_pixel (
    .cfg          (cfg),
    .data_byte    (t),
    .bitmap_width (bitmap_width),
    .src_col      (col_in),
    .src_row      (row_in),
    .pix          (pix)
  );

  always_comb begin
    header_count_next  = hc_in;
    prefix_seen_next   = ps_in;
    header_bytes_next  = hb_in;
    bitmap_width_next  = bitmap_width;
    bitmap_height_next = bitmap_height;
    src_col_next       = col_in;
    src_row_next       = row_in;
    run_left_next      = run_in;
    finished_next      = fin_in;
    lit                = 1'b0;
    do_adv             = 1'b0;
    step_n             = 8'd0;
    if (!fin_in) begin
      if (hc_in != HDR_LEN) begin
        case (hc_in[1:0])
          2'd0: header_bytes_next[7:0]   = t;
          2'd1: header_bytes_next[15:8]  = t;
          2'd2: header_bytes_next[23:16] = t;
          default: ;
        endcase
        header_count_next = hc_in + 3'd1;
        if (hc_in == HDR_LEN - 3'd1) begin
          if (!ps_in && {t, hb_in} == PREFIX_WORD) begin
            prefix_seen_next  = 1'b1;
            header_count_next = 3'd0;
            header_bytes_next = 24'd0;
          end else begin
            bitmap_width_next  = hb_in[15:0];
            bitmap_height_next = hdr_height;
            src_col_next       = 16'd0;
            src_row_next       = 17'd0;
            run_left_next      = 8'd0;
            if (hb_in[15:0] == 16'd0 || hdr_height == 16'd0) begin
              finished_next = 1'b1;
            end
          end
        end
      end else if (run_in != 8'd0) begin
        lit           = 1'b1;
        run_left_next = run_in - 8'd1;
        do_adv        = 1'b1;
        step_n        = 8'd1;
      end else if (t[7] && ({9'd0, t[6:0]} <= bitmap_width)) begin
        // transparent skip of t - 0x80 pixels
        do_adv = 1'b1;
        step_n = t & ~SKIP_FLAG;
      end else begin
        run_left_next = t;
      end

      // step never exceeds the width, so one wrap at most
      if (do_adv) begin
        if (col_sum >= {1'b0, bitmap_width}) begin
          src_row_next = row_in + 17'd1;
          src_col_next = col_sum[15:0] - bitmap_width;
        end else begin
          src_col_next = col_sum[15:0];
        end
      end

      if (header_count_next == HDR_LEN && run_left_next == 8'd0 &&
          src_row_next >= {1'b0, bitmap_height_next}) begin
        finished_next = 1'b1;
      end
    end
  end

  always_comb begin
    result          = lit ? pix : '0;
    result.done_res = finished_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count  <= '0;
      prefix_seen   <= 1'b0;
      header_bytes  <= '0;
      bitmap_width  <= '0;
      bitmap_height <= '0;
      src_col       <= '0;
      src_row       <= '0;
      run_left      <= '0;
      finished      <= 1'b1;
    end else if (go) begin
      header_count  <= header_count_next;
      prefix_seen   <= prefix_seen_next;
      header_bytes  <= header_bytes_next;
      bitmap_width  <= bitmap_width_next;
      bitmap_height <= bitmap_height_next;
      src_col       <= src_col_next;
      src_row       <= src_row_next;
      run_left      <= run_left_next;
      finished      <= finished_next;
    end
  end

endmodule

>>> rtl/rle_sprite_blitter.sv
// Streaming decoder for run-length coded sprites: bytes enter on the byte channel
// (first_byte marks the start of a bitmap) and every byte produces exactly one result
// on the pix channel, either a pixel write or darken request clipped to the surface,
// or an empty result carrying only done_res. The block sustains one byte per clock while
// the pix channel takes its results: each byte is registered on entry, decoded and clipped
// combinationally against the parse state, and registered on exit, and a stalled
// result holds the pipe without losing bytes. Registers are written through the cfg
// port and should only change while no transaction is in flight.
module rle_sprite_blitter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              byte_valid,
  output logic                              byte_ready,
  input  rsb_pkg::byte_t                    byte_item,
  output logic                              pix_valid,
  input  logic                              pix_ready,
  output rsb_pkg::pix_t                     pix_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rsb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rsb_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rsb_pkg::*;

  cfg_t  cfg;
  byte_t in_q;
  logic  in_full;
  logic  go;
  pix_t  result;

  rsb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rsb_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .item   (in_q),
    .cfg    (cfg),
    .result (result)
  );

  assign go         = in_full && (!pix_valid || pix_ready);
  assign byte_ready = !in_full || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_ready) begin
      in_full <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      in_q <= byte_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (go) begin
      pix_valid <= 1'b1;
    end else if (pix_ready) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      pix_item <= result;
    end
  end

  // an empty output stage never backs up the input
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !pix_valid |-> byte_ready)
    else $error("byte channel stalled with empty output stage");

  a_darken_form: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_item.darken |-> pix_item.write_enable && pix_item.color == 8'd0)
    else $error("darken request without write or with color");

  a_no_op_zero: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_item.write_enable |->
      pix_item.pixel_x == 12'd0 && pix_item.pixel_y == 12'd0 &&
      pix_item.color == 8'd0 && !pix_item.darken)
    else $error("empty result carries pixel fields");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    go |=> pix_valid)
    else $error("decoded transaction lost");

endmodule

>>> dv/rsb_blit_checker.sv
module rsb_blit_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            byte_valid,
  input  logic                            byte_ready,
  input  rsb_pkg::byte_t                  byte_item,
  input  logic                            pix_valid,
  input  logic                            pix_ready,
  input  rsb_pkg::pix_t                   pix_item,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [rsb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rsb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fail_count,
  output int                              pix_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import rsb_pkg::*;

  cfg_t        regs;
  int unsigned hdr_cnt;
  logic        prefix_seen;
  logic [31:0] hdr_word;
  logic [15:0] bm_w;
  logic [15:0] bm_h;
  int unsigned col;
  int unsigned row;
  logic [7:0]  run_left;
  logic        finished;
  pix_t        expected_pix[$];

  initial fail_count = 0;

  task automatic report(input string msg);
    if (fail_count < 50) $display("%0t ns: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic logic [3:0] sat_low(input logic [7:0] t);
    int v;
    v = int'(t[3:0]) + int'($signed(regs.color_shift));
    if (v > 15) v = 15;
    if (v < 0) v = 0;
    return v[3:0];
  endfunction

  // source position moves in raster order over bm_w columns
  function automatic void advance(input int unsigned n);
    int unsigned c;
    c = col + n;
    row += c / bm_w;
    col = c % bm_w;
  endfunction

  function automatic pix_t decode_byte(input byte_t b);
    pix_t       r;
    logic [7:0] t;
    logic [7:0] hue;
    logic       mirror;
    logic       shadow;
    longint     x;
    longint     y;
    longint     sw;
    longint     sh;
    r = '0;
    t = b.data_byte;
    if (b.first_byte) begin
      hdr_cnt = 0;
      prefix_seen = 1'b0;
      hdr_word = '0;
      col = 0;
      row = 0;
      run_left = '0;
      finished = 1'b0;
    end
    if (!finished) begin
      if (hdr_cnt < HDR_LEN) begin
        hdr_word |= 32'(t) << (8 * hdr_cnt);
        hdr_cnt++;
        if (hdr_cnt == HDR_LEN) begin
          // only one prefix is honored, the next word is always the size
          if (!prefix_seen && hdr_word == PREFIX_WORD) begin
            prefix_seen = 1'b1;
            hdr_cnt = 0;
            hdr_word = '0;
          end else begin
            bm_w = hdr_word[15:0];
            bm_h = hdr_word[31:16];
            col = 0;
            row = 0;
            run_left = '0;
            if (bm_w == 0 || bm_h == 0) finished = 1'b1;
          end
        end
      end else if (run_left != 0) begin
        mirror = regs.blit_mode[1];
        shadow = !mirror && regs.blit_mode == MODE_SHADOW;
        sw = longint'((regs.surf_width > SURF_MAX) ? SURF_MAX : regs.surf_width);
        sh = longint'((regs.surf_height > SURF_MAX) ? SURF_MAX : regs.surf_height);
        if (mirror) x = longint'($signed(regs.pos_x)) + longint'(bm_w) - 1 - longint'(col);
        else x = longint'($signed(regs.pos_x)) + longint'(col);
        y = longint'($signed(regs.pos_y)) + longint'(row);
        if (x >= 0 && x < sw && y >= 0 && y < sh) begin
          hue = regs.mono_color & NIBBLE_HI;
          r.write_enable = 1'b1;
          r.pixel_x = x[11:0];
          r.pixel_y = y[11:0];
          if (shadow) r.darken = 1'b1;
          else if (hue != 0) r.color = hue | {4'h0, sat_low(t)};
          else if (regs.color_shift != 0) r.color = (t & NIBBLE_HI) | {4'h0, sat_low(t)};
          else r.color = t;
        end
        run_left--;
        advance(1);
      end else if (t[7] && int'(t) <= int'(SKIP_FLAG) + int'(bm_w)) begin
        advance(int'(t) - int'(SKIP_FLAG));
      end else begin
        run_left = t;
      end
      // completion is only looked at between runs
      if (!finished && hdr_cnt == HDR_LEN && run_left == 0 && row >= bm_h) finished = 1'b1;
    end
    r.done_res = finished;
    return r;
  endfunction

  always @(posedge clk) begin
    pix_t want;
    if (rst) begin
      regs = '{pos_x: '0, pos_y: '0, surf_width: SURF_W_RESET, surf_height: SURF_H_RESET,
               blit_mode: MODE_NORMAL, mono_color: '0, color_shift: '0};
      hdr_cnt = 0;
      prefix_seen = 1'b0;
      hdr_word = '0;
      bm_w = '0;
      bm_h = '0;
      col = 0;
      row = 0;
      run_left = '0;
      finished = 1'b1;
      expected_pix.delete();
      pix_pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POS_X:       regs.pos_x = cfg_data;
          CFG_POS_Y:       regs.pos_y = cfg_data;
          CFG_SURF_WIDTH:  regs.surf_width = cfg_data[12:0];
          CFG_SURF_HEIGHT: regs.surf_height = cfg_data[12:0];
          CFG_BLIT_MODE:   regs.blit_mode = cfg_data[1:0];
          CFG_MONO_COLOR:  regs.mono_color = cfg_data[7:0];
          CFG_COLOR_SHIFT: regs.color_shift = cfg_data[4:0];
          default: ;
        endcase
      end
      if (byte_valid && byte_ready) expected_pix.push_back(decode_byte(byte_item));
      if (pix_valid && pix_ready) begin
        if (expected_pix.size() == 0) begin
          report($sformatf("result transaction with nothing expected: %h", pix_item));
        end else begin
          want = expected_pix.pop_front();
          if (pix_item.write_enable !== want.write_enable)
            report($sformatf("write_enable got %0d expected %0d",
                             pix_item.write_enable, want.write_enable));
          if (pix_item.pixel_x !== want.pixel_x)
            report($sformatf("pixel_x got %0d expected %0d", pix_item.pixel_x, want.pixel_x));
          if (pix_item.pixel_y !== want.pixel_y)
            report($sformatf("pixel_y got %0d expected %0d", pix_item.pixel_y, want.pixel_y));
          if (pix_item.color !== want.color)
            report($sformatf("color got %h expected %h", pix_item.color, want.color));
          if (pix_item.darken !== want.darken)
            report($sformatf("darken got %0d expected %0d", pix_item.darken, want.darken));
          if (pix_item.done_res !== want.done_res)
            report($sformatf("done_res got %0d expected %0d", pix_item.done_res, want.done_res));
        end
      end
      pix_pending <= expected_pix.size();
    end
  end

endmodule

>>> dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rsb_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   byte_valid;
  logic                   byte_ready;
  byte_t                  byte_item;
  logic                   pix_valid;
  logic                   pix_ready;
  pix_t                   pix_item;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     fail_count;
  int                     pix_pending;

  int n_sent = 0;
  bit src_pauses = 1'b0;
  bit sink_pauses = 1'b0;
  bit holdoff_done = 1'b0;

  always #6 clk = ~clk;

  rle_sprite_blitter i_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pix_item   (pix_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  rsb_blit_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_item   (byte_item),
    .pix_valid   (pix_valid),
    .pix_ready   (pix_ready),
    .pix_item    (pix_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pix_pending (pix_pending)
  );

  task automatic put_byte(input logic [7:0] d, input logic f);
    int gap;
    gap = 0;
    if (src_pauses && $urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_item <= '{data_byte: d, first_byte: f};
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  // little-endian, first_byte only on the lowest byte
  task automatic put_word(input logic [31:0] w, input logic f);
    for (int i = 0; i < 4; i++) put_byte(w[8*i +: 8], f && i == 0);
  endtask

  task automatic send_header(input bit prefix, input logic [15:0] w, input logic [15:0] h);
    if (prefix) begin
      put_word(PREFIX_WORD, 1'b1);
      put_word({h, w}, 1'b0);
    end else begin
      put_word({h, w}, 1'b1);
    end
  endtask

  // control stream until w*h pixels are covered or the budget of control bytes is spent
  task automatic send_body(input logic [15:0] w, input logic [15:0] h, input int budget);
    longint left;
    int     k;
    int     n;
    int     pick;
    left = longint'(w) * longint'(h);
    while (left > 0 && budget > 0) begin
      pick = $urandom_range(0, 59);
      if (pick < 15) begin
        k = $urandom_range(0, (w > 127) ? 127 : int'(w));
        put_byte(8'(int'(SKIP_FLAG) + k), 1'b0);
        left -= k;
      end else begin
        if (pick < 19) n = 0;
        else if (pick < 23) n = int'((left > 100) ? 100 : left) + $urandom_range(1, 6);
        else if (pick == 23 && w < 120 && $urandom_range(0, 9) == 0)
          n = $urandom_range(129 + int'(w), 132 + int'(w));
        else n = $urandom_range(1, (left > 12) ? 12 : int'(left));
        put_byte(8'(n), 1'b0);
        repeat (n) put_byte(8'($urandom), 1'b0);
        left -= n;
      end
      budget--;
    end
  endtask

  task automatic send_sprite();
    logic [15:0] w;
    logic [15:0] h;
    int          kind;
    kind = $urandom_range(0, 19);
    if (kind < 14) begin
      w = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(1, 40)) : 16'($urandom_range(1, 10));
      h = 16'($urandom_range(1, 6));
      send_header($urandom_range(0, 1), w, h);
      send_body(w, h, (kind == 13) ? $urandom_range(1, 4) : 1_000_000);
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) put_byte(8'($urandom), 1'b0);
    end else if (kind < 16) begin
      // oversized header, cut off by the next restart
      w = 16'($urandom);
      h = 16'($urandom);
      send_header($urandom_range(0, 1), w, h);
      send_body(w, h, $urandom_range(1, 5));
    end else if (kind < 18) begin
      w = 16'($urandom);
      h = 16'($urandom);
      if ($urandom_range(0, 1)) w = '0;
      else h = '0;
      send_header($urandom_range(0, 1), w, h);
      if ($urandom_range(0, 1)) put_byte(8'($urandom), 1'b0);
    end else begin
      repeat ($urandom_range(1, 8)) put_byte(8'($urandom), $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_cfg(input cfg_index_t idx);
    logic [CFG_DATA_W-1:0] v;
    logic [CFG_DATA_W-1:0] mask;
    v = '0;
    mask = '1;
    case (idx)
      CFG_POS_X, CFG_POS_Y: begin
        case ($urandom_range(0, 7))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          2: v = 16'($urandom);
          3: v = 16'($urandom_range(0, 4100));
          default: v = 16'($urandom_range(0, 50)) - 16'd15;
        endcase
      end
      CFG_SURF_WIDTH, CFG_SURF_HEIGHT: begin
        mask = 16'h1fff;
        case ($urandom_range(0, 7))
          0: v = 16'd0;
          1: v = 16'($urandom_range(4096, 8191));
          2: v = 16'($urandom_range(0, 8191));
          default: v = 16'($urandom_range(4, 330));
        endcase
      end
      CFG_BLIT_MODE: begin
        mask = 16'h3;
        v = 16'($urandom_range(0, 3));
      end
      CFG_MONO_COLOR: begin
        mask = 16'hff;
        v = $urandom_range(0, 1) ? 16'($urandom_range(0, 255)) : 16'd0;
      end
      default: begin
        mask = 16'h1f;
        v = $urandom_range(0, 1) ? 16'($urandom_range(0, 31)) : 16'd0;
      end
    endcase
    // unused upper bits of the data word must be ignored
    if ($urandom_range(0, 3) == 0) v |= 16'($urandom) & ~mask;
    return v;
  endfunction

  task automatic load_setup(input int phase);
    case (phase)
      0: begin
        write_reg(CFG_POS_X, 16'd0);
        write_reg(CFG_POS_Y, 16'd0);
        write_reg(CFG_SURF_WIDTH, 16'd4096);
        write_reg(CFG_SURF_HEIGHT, 16'h1fff);
        write_reg(CFG_BLIT_MODE, {14'd0, MODE_MIRROR});
        write_reg(CFG_MONO_COLOR, 16'hff);
        write_reg(CFG_COLOR_SHIFT, 16'h0f);
        write_reg(CFG_UNUSED, 16'hffff);
      end
      1: begin
        write_reg(CFG_POS_X, 16'h8000);
        write_reg(CFG_POS_Y, 16'h7fff);
        write_reg(CFG_SURF_WIDTH, 16'd0);
        write_reg(CFG_SURF_HEIGHT, 16'd0);
        write_reg(CFG_BLIT_MODE, {14'd0, MODE_SHADOW | MODE_MIRROR});
        write_reg(CFG_MONO_COLOR, 16'd0);
        write_reg(CFG_COLOR_SHIFT, 16'h10);
      end
      2: begin
        write_reg(CFG_POS_X, 16'hfffd);
        write_reg(CFG_POS_Y, 16'hfffe);
        write_reg(CFG_SURF_WIDTH, 16'd5);
        write_reg(CFG_SURF_HEIGHT, 16'd4);
        write_reg(CFG_BLIT_MODE, {14'd0, MODE_SHADOW});
        write_reg(CFG_MONO_COLOR, 16'h35);
        write_reg(CFG_COLOR_SHIFT, 16'd0);
      end
      3: begin
        write_reg(CFG_POS_X, 16'd4090);
        write_reg(CFG_POS_Y, 16'd4093);
        write_reg(CFG_SURF_WIDTH, 16'd4096);
        write_reg(CFG_SURF_HEIGHT, 16'd4096);
        write_reg(CFG_BLIT_MODE, {14'd0, MODE_MIRROR});
        write_reg(CFG_MONO_COLOR, 16'h0f);
        write_reg(CFG_COLOR_SHIFT, 16'h10);
      end
      default: begin
        for (int r = 0; r < 7; r++)
          if ($urandom_range(0, 1)) write_reg(CFG_INDEX_W'(r), rand_cfg(cfg_index_t'(r)));
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  // registers only change once every result is back
  task automatic settle();
    byte_valid <= 1'b0;
    wait (pix_pending == 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int phase;
    int target;
    rst = 1'b1;
    byte_valid = 1'b0;
    byte_item = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_POS_X;
    cfg_data = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // 2x2: empty run, skip, literal, row wrap, then a byte while idle
    put_word(32'h0002_0002, 1'b1);
    put_byte(8'h00, 1'b0);
    put_byte(8'h81, 1'b0);
    put_byte(8'h01, 1'b0);
    put_byte(8'haa, 1'b0);
    put_byte(8'h02, 1'b0);
    put_byte(8'h0f, 1'b0);
    put_byte(8'hf0, 1'b0);
    put_byte(8'h33, 1'b0);
    // second prefix word is taken as the size: 2x0, empty bitmap
    put_word(PREFIX_WORD, 1'b1);
    put_word(PREFIX_WORD, 1'b0);
    // restart in the middle of a header, then a run past the last row
    put_byte(8'h07, 1'b1);
    put_byte(8'h00, 1'b0);
    put_word(32'h0001_0001, 1'b1);
    put_byte(8'h02, 1'b0);
    put_byte(8'hff, 1'b0);
    put_byte(8'h00, 1'b0);

    phase = 0;
    while (n_sent < 1430) begin
      settle();
      load_setup(phase);
      src_pauses = $urandom_range(0, 2) != 0;
      sink_pauses = $urandom_range(0, 2) != 0;
      target = n_sent + $urandom_range(60, 140);
      while (n_sent < target) send_sprite();
      phase++;
    end
    byte_valid <= 1'b0;

    wait (pix_pending == 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    int stall;
    stall = 0;
    pix_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!holdoff_done && n_sent >= 500) begin
        // long hold-off so the pipe fills and the byte side backs up
        pix_ready <= 1'b0;
        repeat (150) @(negedge clk);
        holdoff_done = 1'b1;
      end else if (stall > 0) begin
        pix_ready <= 1'b0;
        stall--;
      end else begin
        pix_ready <= 1'b1;
        if (sink_pauses && $urandom_range(0, 3) == 0)
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      end
    end
  end

  initial begin
    #10ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
